@@ rtl/bmm_pkg.sv @@
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared types and constants of the block matrix multiply unit: default
// matrix size, element width, controller states and the command and status
// groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bmm_pkg;

	// Default matrix dimension (rows = columns)
	localparam int MATRIX_SIZE_DEF = 4;

	// Element and product width
	localparam int DATA_W = 32;

	// Width of the row and column fields on the result stream
	localparam int INDEX_FIELD_W = 2;

	// Controller states
	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ISSUE,
		ST_DRAIN,
		ST_EMIT
	} bmm_state_t;

	// Controller to datapath
	typedef struct packed {
		logic wr_en;     // store one element pair
		logic rd_en;     // read one operand pair for a multiply-accumulate
		logic out_load;  // move the finished sum into the output register
		logic out_last;  // the sum being moved is the final one of the burst
	} bmm_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic pipe_busy; // multiply-accumulate pipeline still holds work
		logic out_free;  // output register can take a new item this cycle
	} bmm_status_t;

endpackage

`default_nettype wire

@@ rtl/bmm_ram.sv @@
// ----------------------------------------------------------------------------
// bmm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bmm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/bmm_datapath.sv @@
// ----------------------------------------------------------------------------
// bmm_datapath
// Operand stores, multiply-accumulate pipeline and output register.
// Read, multiply and accumulate each take one register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bmm_datapath #(
	parameter int MATRIX_SIZE = bmm_pkg::MATRIX_SIZE_DEF,
	localparam int ELEM_COUNT = MATRIX_SIZE * MATRIX_SIZE,
	localparam int ADDR_W     = $clog2(ELEM_COUNT),
	localparam int IDX_W      = $clog2(MATRIX_SIZE)
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire bmm_pkg::bmm_cmd_t                cmd,
	output bmm_pkg::bmm_status_t                  status,
	input  wire logic [ADDR_W-1:0]                wr_addr,
	input  wire logic [ADDR_W-1:0]                rd_addr_left,
	input  wire logic [ADDR_W-1:0]                rd_addr_right,
	input  wire logic [IDX_W-1:0]                 out_row,
	input  wire logic [IDX_W-1:0]                 out_col,
	input  wire logic [bmm_pkg::DATA_W-1:0]       left_element,
	input  wire logic [bmm_pkg::DATA_W-1:0]       right_element,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [bmm_pkg::DATA_W-1:0]            product_value,
	output logic [bmm_pkg::INDEX_FIELD_W-1:0]     row_index,
	output logic [bmm_pkg::INDEX_FIELD_W-1:0]     col_index,
	output logic                                  last_flag
);

	logic [bmm_pkg::DATA_W-1:0] left_rdata;
	logic [bmm_pkg::DATA_W-1:0] right_rdata;
	logic [bmm_pkg::DATA_W-1:0] product;
	logic [bmm_pkg::DATA_W-1:0] prod_s2;
	logic [bmm_pkg::DATA_W-1:0] acc_q;
	logic                       valid_s1;
	logic                       valid_s2;
	logic                       out_valid_q;

	bmm_ram #(
		.WIDTH (bmm_pkg::DATA_W),
		.DEPTH (ELEM_COUNT)
	) u_left_ram (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (wr_addr),
		.wr_data (left_element),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr_left),
		.rd_data (left_rdata)
	);

	bmm_ram #(
		.WIDTH (bmm_pkg::DATA_W),
		.DEPTH (ELEM_COUNT)
	) u_right_ram (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (wr_addr),
		.wr_data (right_element),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr_right),
		.rd_data (right_rdata)
	);

	// Low half of the product; identical for signed and unsigned operands
	assign product = left_rdata * right_rdata;

	// Track operand pairs through the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_en;
			valid_s2 <= valid_s1;
		end
	end

	// Register the product
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			prod_s2 <= product;
		end
	end

	// Accumulate; clear once the sum has moved to the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.out_load) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + prod_s2;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			product_value <= acc_q;
			row_index     <= bmm_pkg::INDEX_FIELD_W'(out_row);
			col_index     <= bmm_pkg::INDEX_FIELD_W'(out_col);
			last_flag     <= cmd.out_last;
		end
	end

	assign out_valid        = out_valid_q;
	assign status.pipe_busy = valid_s1 | valid_s2;
	assign status.out_free  = !out_valid_q || out_ready;

endmodule

`default_nettype wire

@@ rtl/bmm_controller.sv @@
// ----------------------------------------------------------------------------
// bmm_controller
// Sequencer for load, multiply-accumulate and emit. Holds the load count
// and the row, column and inner-index counters and drives the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module bmm_controller #(
	parameter int MATRIX_SIZE = bmm_pkg::MATRIX_SIZE_DEF,
	localparam int ELEM_COUNT = MATRIX_SIZE * MATRIX_SIZE,
	localparam int ADDR_W     = $clog2(ELEM_COUNT),
	localparam int IDX_W      = $clog2(MATRIX_SIZE)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire bmm_pkg::bmm_status_t  status,
	output bmm_pkg::bmm_cmd_t          cmd,
	output logic [ADDR_W-1:0]          wr_addr,
	output logic [ADDR_W-1:0]          rd_addr_left,
	output logic [ADDR_W-1:0]          rd_addr_right,
	output logic [IDX_W-1:0]           out_row,
	output logic [IDX_W-1:0]           out_col
);

	bmm_pkg::bmm_state_t state_q;
	bmm_pkg::bmm_state_t state_d;

	logic [ADDR_W-1:0] load_cnt_q;
	logic [IDX_W-1:0]  row_q;
	logic [IDX_W-1:0]  col_q;
	logic [IDX_W-1:0]  k_q;
	logic              load_done;
	logic              k_done;
	logic              col_done;
	logic              row_done;

	assign load_done = (load_cnt_q == ADDR_W'(ELEM_COUNT - 1));
	assign k_done    = (k_q == IDX_W'(MATRIX_SIZE - 1));
	assign col_done  = (col_q == IDX_W'(MATRIX_SIZE - 1));
	assign row_done  = (row_q == IDX_W'(MATRIX_SIZE - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bmm_pkg::ST_LOAD: begin
				if (in_valid && load_done) begin
					state_d = bmm_pkg::ST_ISSUE;
				end
			end
			bmm_pkg::ST_ISSUE: begin
				if (k_done) begin
					state_d = bmm_pkg::ST_DRAIN;
				end
			end
			bmm_pkg::ST_DRAIN: begin
				if (!status.pipe_busy) begin
					state_d = bmm_pkg::ST_EMIT;
				end
			end
			bmm_pkg::ST_EMIT: begin
				if (status.out_free) begin
					state_d = (row_done && col_done) ? bmm_pkg::ST_LOAD : bmm_pkg::ST_ISSUE;
				end
			end
			default: state_d = bmm_pkg::ST_LOAD;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready     = 1'b0;
		cmd.wr_en    = 1'b0;
		cmd.rd_en    = 1'b0;
		cmd.out_load = 1'b0;
		cmd.out_last = 1'b0;
		unique case (state_q)
			bmm_pkg::ST_LOAD: begin
				in_ready  = 1'b1;
				cmd.wr_en = in_valid;
			end
			bmm_pkg::ST_ISSUE: begin
				cmd.rd_en = 1'b1;
			end
			bmm_pkg::ST_DRAIN: begin
			end
			bmm_pkg::ST_EMIT: begin
				cmd.out_load = status.out_free;
				cmd.out_last = row_done && col_done;
			end
			default: begin
			end
		endcase
	end

	// Operand addresses: left walks a row, right walks a column
	assign wr_addr       = load_cnt_q;
	assign rd_addr_left  = ADDR_W'(ADDR_W'(row_q) * ADDR_W'(MATRIX_SIZE) + ADDR_W'(k_q));
	assign rd_addr_right = ADDR_W'(ADDR_W'(k_q) * ADDR_W'(MATRIX_SIZE) + ADDR_W'(col_q));
	assign out_row       = row_q;
	assign out_col       = col_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmm_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance the load count; wrap after the final element
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
		end else if (cmd.wr_en) begin
			load_cnt_q <= load_done ? '0 : load_cnt_q + ADDR_W'(1);
		end
	end

	// Advance the inner index per issued operand pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cmd.rd_en) begin
			k_q <= k_done ? '0 : k_q + IDX_W'(1);
		end
	end

	// Advance column and row per emitted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cmd.out_load) begin
			if (col_done) begin
				col_q <= '0;
				row_q <= row_done ? '0 : row_q + IDX_W'(1);
			end else begin
				col_q <= col_q + IDX_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/block_matrix_multiply_unit.sv @@
// Throughput: one element pair loads per cycle while the unit is in its load
// state; after the final pair each of the N*N results is formed by N operand
// reads through one shared multiply-accumulate pipeline, its drain and an emit
// step, and the next load waits until the final result is moved out. Reset
// clears control state and the accumulator only; operand stores hold garbage
// until the first load and need no clearing pass.
// ----------------------------------------------------------------------------
// block_matrix_multiply_unit
// Streaming N x N signed integer matrix multiplier. Loads both matrices in
// row-major order, then emits the product row-major, wrapping modulo 2^32.
// ----------------------------------------------------------------------------
`default_nettype none

module block_matrix_multiply_unit #(
	parameter int MATRIX_SIZE = bmm_pkg::MATRIX_SIZE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,  // left_element[31:0], right_element[63:32]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // product_value[31:0], row_index[33:32],
	                                        // col_index[35:34], zero[39:36]
	output logic             m_axis_tlast
);

	localparam int ELEM_COUNT = MATRIX_SIZE * MATRIX_SIZE;
	localparam int ADDR_W     = $clog2(ELEM_COUNT);
	localparam int IDX_W      = $clog2(MATRIX_SIZE);

	bmm_pkg::bmm_cmd_t    cmd;
	bmm_pkg::bmm_status_t status;

	logic [ADDR_W-1:0]                    wr_addr;
	logic [ADDR_W-1:0]                    rd_addr_left;
	logic [ADDR_W-1:0]                    rd_addr_right;
	logic [IDX_W-1:0]                     out_row;
	logic [IDX_W-1:0]                     out_col;
	logic [bmm_pkg::DATA_W-1:0]           product_value;
	logic [bmm_pkg::INDEX_FIELD_W-1:0]    row_index;
	logic [bmm_pkg::INDEX_FIELD_W-1:0]    col_index;

	bmm_controller #(
		.MATRIX_SIZE (MATRIX_SIZE)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.status        (status),
		.cmd           (cmd),
		.wr_addr       (wr_addr),
		.rd_addr_left  (rd_addr_left),
		.rd_addr_right (rd_addr_right),
		.out_row       (out_row),
		.out_col       (out_col)
	);

	bmm_datapath #(
		.MATRIX_SIZE (MATRIX_SIZE)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.wr_addr       (wr_addr),
		.rd_addr_left  (rd_addr_left),
		.rd_addr_right (rd_addr_right),
		.out_row       (out_row),
		.out_col       (out_col),
		.left_element  (s_axis_tdata[31:0]),
		.right_element (s_axis_tdata[63:32]),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.product_value (product_value),
		.row_index     (row_index),
		.col_index     (col_index),
		.last_flag     (m_axis_tlast)
	);

	// Pack the result item
	assign m_axis_tdata = {4'b0000, col_index, row_index, product_value};

	// No new result right after the final one of a burst is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
		else $error("result follows the final item of a burst");

	// Loading never overlaps multiply-accumulate work
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !status.pipe_busy)
		else $error("input accepted while the pipeline is busy");

	// A sum is emitted only once every product has been accumulated
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !status.pipe_busy)
		else $error("sum emitted before the pipeline drained");

	// Operand reads never coincide with stores
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rd_en && cmd.wr_en))
		else $error("operand read during a load");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the 4x4 block matrix multiply unit. Element pairs are fed
// row-major through the input stream with random gaps; every sixteenth item
// completes a load and a local copy of the matrices predicts the sixteen
// product items, which are checked field by field against the result stream
// under random back-pressure.
// ----------------------------------------------------------------------------

module tb_top;

	localparam int N          = bmm_pkg::MATRIX_SIZE_DEF;
	localparam int ELEMS      = N * N;
	localparam int W          = bmm_pkg::DATA_W;
	localparam int IW         = bmm_pkg::INDEX_FIELD_W;
	localparam int IDLE_LIMIT = 2000;
	localparam int RAND_LOADS = 14;

	localparam logic [W-1:0] EDGE_VALUES [8] = '{
		32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
		32'h0000_0001, 32'h0000_0002, 32'h5555_5555, 32'hAAAA_AAAA
	};

	typedef struct {
		logic [W-1:0] left;
		logic [W-1:0] right;
		int unsigned  gap;
		bit           drain;
	} elem_pair_t;

	typedef struct packed {
		logic [W-1:0]  value;
		logic [IW-1:0] row;
		logic [IW-1:0] col;
		logic          last;
	} product_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;

	elem_pair_t   pending_pairs[$];
	product_t     expected_products[$];
	logic [W-1:0] left_matrix [ELEMS];
	logic [W-1:0] right_matrix [ELEMS];
	int unsigned  load_pos = 0;
	int unsigned  items_taken = 0;
	int unsigned  planned_items = 0;
	int unsigned  error_count = 0;
	int unsigned  idle_cycles = 0;
	logic         products_drained = 1'b1;
	int unsigned  send_gap_left = 0;
	bit           send_gap_armed = 0;
	int unsigned  stall_left = 0;
	int unsigned  stretch_left = 0;
	bit           quiet_stretch = 0;

	block_matrix_multiply_unit #(.MATRIX_SIZE(N)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Clock, 4 ns period
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Element value for a given content style
	function automatic logic [W-1:0] pick_value(int unsigned style);
		case (style)
			0: return $urandom();
			1: return $urandom_range(0, 16) - 8;
			default: begin
				if ($urandom_range(0, 2) == 0)
					return $urandom();
				return EDGE_VALUES[$urandom_range(0, 7)];
			end
		endcase
	endfunction

	task automatic queue_pair(logic [W-1:0] left, logic [W-1:0] right,
	                          int unsigned gap, bit drain);
		elem_pair_t p;
		p.left  = left;
		p.right = right;
		p.gap   = gap;
		p.drain = drain;
		pending_pairs.push_back(p);
	endtask

	task automatic report_mismatch(string field, logic [W-1:0] got, logic [W-1:0] want);
		$display("%0t: mismatch on %s: got %h, want %h", $realtime, field, got, want);
		error_count++;
	endtask

	// Full product of the loaded matrices, summed block by block, row-major
	task automatic multiply_loaded_matrices();
		product_t     p;
		logic [W-1:0] acc;
		int           k;
		for (int r = 0; r < N; r++) begin
			for (int c = 0; c < N; c++) begin
				acc = '0;
				for (int kb = 0; kb < N; kb += 2) begin
					for (int kk = 0; kk < 2; kk++) begin
						k = kb + kk;
						acc = acc + left_matrix[r * N + k] * right_matrix[k * N + c];
					end
				end
				p.value = acc;
				p.row   = IW'(r);
				p.col   = IW'(c);
				p.last  = (r == N - 1) && (c == N - 1);
				expected_products.push_back(p);
			end
		end
	endtask

	// Input driver: present the front pair after its gap, hold until taken
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				void'(pending_pairs.pop_front());
				send_gap_armed = 0;
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the item
			end else if (pending_pairs.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				if (!send_gap_armed) begin
					send_gap_left = pending_pairs[0].gap;
					send_gap_armed = 1;
				end
				if (send_gap_left > 0) begin
					send_gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_pairs[0].drain && !products_drained) begin
					s_axis_tvalid <= 1'b0;
				end else begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {pending_pairs[0].right, pending_pairs[0].left};
				end
			end
		end
	end

	// Result back-pressure, with quiet stretches of steady ready
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (stretch_left == 0) begin
				quiet_stretch = ($urandom_range(0, 2) == 0);
				stretch_left = $urandom_range(50, 400);
			end else begin
				stretch_left--;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (!quiet_stretch && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// Monitor: track loads, predict bursts, check results, watch for a hang
	always @(posedge clk) begin
		product_t got;
		product_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				left_matrix[load_pos] = s_axis_tdata[W-1:0];
				right_matrix[load_pos] = s_axis_tdata[2*W-1:W];
				items_taken++;
				if (load_pos == ELEMS - 1) begin
					load_pos = 0;
					multiply_loaded_matrices();
				end else begin
					load_pos++;
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.value = m_axis_tdata[W-1:0];
				got.row   = m_axis_tdata[W+IW-1:W];
				got.col   = m_axis_tdata[W+2*IW-1:W+IW];
				got.last  = m_axis_tlast;
				if (expected_products.size() == 0) begin
					report_mismatch("result with none pending", got.value, '0);
				end else begin
					want = expected_products.pop_front();
					if (got.value !== want.value)
						report_mismatch("product_value", got.value, want.value);
					if (got.row !== want.row)
						report_mismatch("row_index", W'(got.row), W'(want.row));
					if (got.col !== want.col)
						report_mismatch("col_index", W'(got.col), W'(want.col));
					if (got.last !== want.last)
						report_mismatch("last_flag", W'(got.last), W'(want.last));
				end
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		products_drained <= (expected_products.size() == 0);
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Stimulus plan and end of run
	initial begin
		int unsigned style;
		int unsigned gap;
		bit          quiet_load;
		bit          drain_load;
		logic [W-1:0] right;

		// Directed load: corner values on both sides, all bits toggled
		for (int i = 0; i < ELEMS; i++) begin
			if (i < 8)
				right = EDGE_VALUES[(i * 3) % 8];
			else
				right = EDGE_VALUES[i % 8];
			queue_pair(EDGE_VALUES[i % 8], right, 0, 0);
		end

		// Random loads with varied content; a few wait for the previous burst
		for (int ld = 0; ld < RAND_LOADS; ld++) begin
			style = $urandom_range(0, 3);
			quiet_load = ($urandom_range(0, 3) == 0);
			drain_load = (ld == 2) || (ld == 7) || ($urandom_range(0, 5) == 0);
			for (int i = 0; i < ELEMS; i++) begin
				gap = quiet_load ? 0 : pick_gap();
				if (i == 0 && drain_load && gap == 0)
					gap = 1;
				if (style == 3)
					right = (i / N == i % N) ? W'(1) : W'(0);
				else
					right = pick_value(style);
				queue_pair(pick_value(style == 3 ? 0 : style), right, gap,
				           (i == 0) && drain_load);
			end
		end
		planned_items = pending_pairs.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (!(items_taken == planned_items && expected_products.size() == 0))
			@(negedge clk);
		repeat (30) @(posedge clk);

		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
